@@ hw/rtl/art_pkg.sv @@
// Package: types, constants and codes for the address region table.
`default_nettype none
package art_pkg;
  localparam int MaxRegions = 16;
  localparam int PageShift  = 12;
  localparam int PageW      = 64 - PageShift;
  localparam int IdxW       = $clog2(MaxRegions);
  localparam int CntW       = $clog2(MaxRegions + 1);
  localparam int EntryW     = 2 * PageW + 8;
  localparam logic [PageW-1:0] FloorPages = PageW'(4);

  localparam logic [1:0] OpInsert = 2'd0;
  localparam logic [1:0] OpRemove = 2'd1;
  localparam logic [1:0] OpFind   = 2'd2;
  localparam logic [1:0] OpGap    = 2'd3;

  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StMissing = 3'd1;
  localparam logic [2:0] StOverlap = 3'd2;
  localparam logic [2:0] StFull    = 3'd3;
  localparam logic [2:0] StInvalid = 3'd4;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] addr_a;
    logic [63:0] addr_b;
    logic [63:0] req_length;
    logic [7:0]  region_flag_bits;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] hit_start;
    logic [63:0] hit_end;
    logic [7:0]  hit_flags;
    logic [63:0] gap_address;
    logic [4:0]  entries_used;
  } out_item_t;

  typedef struct packed {
    logic [PageW-1:0] start_page;
    logic [PageW-1:0] end_page;
    logic [7:0]       flags;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_SCAN_RD, S_SCAN, S_SHIFT_RD, S_SHIFT_WR, S_PUT,
    S_GAP_LAST, S_DONE
  } state_t;
endpackage
`default_nettype wire

@@ hw/rtl/art_ram.sv @@
// Generic single-port-write, one-read RAM with registered read data.
`default_nettype none
module art_ram #(
  parameter int Depth = 16,
  parameter int Width = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ hw/rtl/address_region_table.sv @@
// Address region table: top level with sequencer over the entry memory.
// Holds up to MaxRegions sorted, non-overlapping page regions in one RAM of
// entries (start page, end page, flags), read one entry at a time with
// registered read data. Every operation that passes its checks walks the
// used entries in order, each entry read, then compared. A remove shifts
// the entries above the hit down; an accepted insert shifts the entries at
// and above its position up after the walk, then writes the new entry. The
// result is held in an output register until transferred; the next item is
// taken once that transfer is done.
`default_nettype none
module address_region_table (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire art_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output art_pkg::out_item_t     out_data
);
  localparam int PW = art_pkg::PageW;
  localparam int IW = art_pkg::IdxW;
  localparam int CW = art_pkg::CntW;

  art_pkg::state_t   state, state_next;
  art_pkg::in_item_t req;
  logic [CW-1:0]     used, cnt;     // cnt: walk index
  logic [CW-1:0]     pos;           // insert position
  logic              pos_found;
  logic              overlap;
  logic [PW-1:0]     sp, prev_end;
  logic [PW:0]       ep, lp;        // one spare bit: rounding up may carry out
  logic [2:0]        status;
  logic [63:0]       hs, he, gap;
  logic [7:0]        hf;

  // entry memory
  logic              we;
  logic [IW-1:0]     waddr, raddr;
  art_pkg::entry_t   wdata, rdata;
  logic [art_pkg::EntryW-1:0] rbits;

  art_ram #(.Depth(art_pkg::MaxRegions), .Width(art_pkg::EntryW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr),
    .rdata(rbits)
  );
  assign rdata = art_pkg::entry_t'(rbits);

  // page rounding of the incoming item
  logic [PW-1:0] a_pg;
  logic [PW:0]   b_up_w, l_up_w;
  always_comb begin
    a_pg   = in_data.addr_a[63:art_pkg::PageShift];
    b_up_w = {1'b0, in_data.addr_b[63:art_pkg::PageShift]} +
             (PW+1)'(in_data.addr_b[art_pkg::PageShift-1:0] != '0);
    l_up_w = {1'b0, in_data.req_length[63:art_pkg::PageShift]} +
             (PW+1)'(in_data.req_length[art_pkg::PageShift-1:0] != '0);
  end

  // gap candidate for the current window [low, high)
  logic [PW-1:0] cand_low;
  logic [PW:0]   cand_high;
  logic          cand_ok;
  logic [PW-1:0] low0;
  always_comb begin
    low0     = (sp > art_pkg::FloorPages) ? sp : art_pkg::FloorPages;
    cand_low = (prev_end > low0) ? prev_end : low0;
    cand_high = ep;
    if (state == art_pkg::S_SCAN && {1'b0, rdata.start_page} < ep)
      cand_high = {1'b0, rdata.start_page};
    cand_ok = ({1'b0, cand_low} < cand_high) &&
              (lp <= cand_high - {1'b0, cand_low});
  end

  assign in_ready = (state == art_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= art_pkg::S_IDLE;
    else     state <= state_next;
  end

  // decisions of the walk
  logic            check_bad, scan_stop, shift_end;
  art_pkg::state_t scan_next, scan_end_next, shift_end_next;
  logic            contains;
  always_comb begin
    check_bad = 1'b0;
    if (req.op == art_pkg::OpInsert)
      check_bad = (req.addr_a >= req.addr_b) || ep[PW];
    else if (req.op == art_pkg::OpGap)
      check_bad = (req.addr_a >= req.addr_b) || (req.req_length == '0) ||
                  (req.addr_b - req.addr_a < req.req_length);
    contains  = (sp >= rdata.start_page) && (sp < rdata.end_page);
    scan_stop = 1'b0;
    scan_next = art_pkg::S_DONE;
    case (req.op)
      art_pkg::OpRemove, art_pkg::OpFind: begin
        scan_stop = (sp < rdata.start_page) || contains;
        scan_next = (contains && req.op == art_pkg::OpRemove) ?
                    art_pkg::S_SHIFT_RD : art_pkg::S_DONE;
      end
      art_pkg::OpGap: scan_stop = cand_ok;
      default: ;
    endcase
    // end of the walk without an early stop
    case (req.op)
      art_pkg::OpGap:    scan_end_next = art_pkg::S_GAP_LAST;
      art_pkg::OpInsert: scan_end_next = (overlap || used == CW'(art_pkg::MaxRegions))
                                         ? art_pkg::S_DONE : art_pkg::S_SHIFT_RD;
      default:           scan_end_next = art_pkg::S_DONE;
    endcase
    if (req.op == art_pkg::OpInsert) begin
      shift_end      = (cnt == pos);
      shift_end_next = art_pkg::S_PUT;
    end else begin
      shift_end      = (cnt + 1'b1 >= used);
      shift_end_next = art_pkg::S_DONE;
    end
  end

  // next state and memory control
  always_comb begin
    state_next = state;
    we    = 1'b0;
    waddr = cnt[IW-1:0];
    wdata = rdata;
    raddr = cnt[IW-1:0];
    case (state)
      art_pkg::S_IDLE:     if (in_valid) state_next = art_pkg::S_CHECK;
      art_pkg::S_CHECK:    state_next = (used == '0) ?
                             ((req.op == art_pkg::OpGap) ? art_pkg::S_GAP_LAST
                              : (req.op == art_pkg::OpInsert) ? art_pkg::S_PUT
                              : art_pkg::S_DONE)
                             : art_pkg::S_SCAN_RD;
      art_pkg::S_SCAN_RD:  state_next = art_pkg::S_SCAN;
      art_pkg::S_SCAN:     state_next = art_pkg::S_SCAN_RD;
      art_pkg::S_SHIFT_RD: begin
        // insert reads cnt-1, remove reads cnt+1
        raddr = (req.op == art_pkg::OpInsert) ? IW'(cnt - 1'b1) : IW'(cnt + 1'b1);
        state_next = art_pkg::S_SHIFT_WR;
      end
      art_pkg::S_SHIFT_WR: begin
        we = 1'b1;
        state_next = art_pkg::S_SHIFT_RD;
      end
      art_pkg::S_PUT: begin
        we    = 1'b1;
        waddr = pos[IW-1:0];
        wdata = '{start_page: sp, end_page: ep[PW-1:0], flags: req.region_flag_bits};
        state_next = art_pkg::S_DONE;
      end
      art_pkg::S_GAP_LAST: state_next = art_pkg::S_DONE;
      art_pkg::S_DONE:     if (out_ready) state_next = art_pkg::S_IDLE;
      default:             state_next = art_pkg::S_IDLE;
    endcase
    // early exits decided in the sequential block are reflected by its writes
    if (state == art_pkg::S_SCAN && scan_stop) state_next = scan_next;
    if (state == art_pkg::S_SCAN_RD && cnt >= used) state_next = scan_end_next;
    if (state == art_pkg::S_SHIFT_RD && shift_end) state_next = shift_end_next;
    if (state == art_pkg::S_CHECK && check_bad) state_next = art_pkg::S_DONE;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else begin
      case (state)
        art_pkg::S_IDLE: if (in_valid) begin
          req <= in_data; sp <= a_pg; ep <= b_up_w; lp <= l_up_w;
          cnt <= '0; pos <= '0; pos_found <= 1'b0; overlap <= 1'b0;
          prev_end <= '0;
          status <= art_pkg::StOk; hs <= '0; he <= '0; hf <= '0; gap <= '0;
        end
        art_pkg::S_CHECK: begin
          if (check_bad) status <= art_pkg::StInvalid;
          else if (used == '0 && (req.op == art_pkg::OpRemove ||
                                  req.op == art_pkg::OpFind))
            status <= art_pkg::StMissing;
        end
        art_pkg::S_SCAN_RD: if (cnt >= used) begin
          if (req.op == art_pkg::OpInsert) begin
            if (!pos_found) pos <= used;
            if (overlap) status <= art_pkg::StOverlap;
            else if (used == CW'(art_pkg::MaxRegions)) status <= art_pkg::StFull;
            else cnt <= used;
          end else if (req.op != art_pkg::OpGap) status <= art_pkg::StMissing;
        end
        art_pkg::S_SCAN: begin
          // a remove keeps the index of the hit for the shift
          if (!(contains && (req.op == art_pkg::OpRemove ||
                             req.op == art_pkg::OpFind)))
            cnt <= cnt + 1'b1;
          prev_end <= rdata.end_page;
          case (req.op)
            art_pkg::OpInsert: begin
              if (sp < rdata.end_page && {1'b0, rdata.start_page} < ep)
                overlap <= 1'b1;
              if (!pos_found && !(rdata.start_page < sp)) begin
                pos <= cnt; pos_found <= 1'b1;
              end
            end
            art_pkg::OpGap:
              if (cand_ok) gap <= {cand_low, {art_pkg::PageShift{1'b0}}};
            default:
              if (contains) begin
                hs <= {rdata.start_page, {art_pkg::PageShift{1'b0}}};
                he <= {rdata.end_page, {art_pkg::PageShift{1'b0}}};
                hf <= rdata.flags;
              end else if (sp < rdata.start_page) status <= art_pkg::StMissing;
          endcase
        end
        art_pkg::S_SHIFT_RD: if (shift_end) begin
          if (req.op == art_pkg::OpRemove) used <= used - 1'b1;
        end
        art_pkg::S_SHIFT_WR:
          cnt <= (req.op == art_pkg::OpInsert) ? cnt - 1'b1 : cnt + 1'b1;
        art_pkg::S_PUT: used <= used + 1'b1;
        art_pkg::S_GAP_LAST: begin
          if (cand_ok) gap <= {cand_low, {art_pkg::PageShift{1'b0}}};
          else status <= art_pkg::StInvalid;
        end
        default: ;
      endcase
    end
  end

  assign out_valid = (state == art_pkg::S_DONE);
  always_comb begin
    out_data.status       = status;
    out_data.hit_start    = hs;
    out_data.hit_end      = he;
    out_data.hit_flags    = hf;
    out_data.gap_address  = gap;
    out_data.entries_used = 5'(used);
  end

  // checks
  a_used_max: assert property (@(posedge clk) disable iff (rst)
    used <= CW'(art_pkg::MaxRegions)) else $error("entry count beyond depth");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped before transfer");
endmodule
`default_nettype wire

@@ tb/tb.sv @@
// Testbench for the address region table: directed table then random traffic.
`timescale 1ns / 1ps
module tb;
  localparam int WatchdogLimit = 20000;
  localparam int NumRandom     = 1030;
  localparam logic [63:0] PgMask = 64'hFFF;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  art_pkg::in_item_t in_data;
  logic out_valid;
  logic out_ready;
  art_pkg::out_item_t out_data;

  address_region_table u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Shadow copy of the region table
  logic [art_pkg::PageW-1:0] mdl_start [art_pkg::MaxRegions];
  logic [art_pkg::PageW-1:0] mdl_end   [art_pkg::MaxRegions];
  logic [7:0]                mdl_flags [art_pkg::MaxRegions];
  int                        mdl_used;

  art_pkg::out_item_t result_queue[$];
  int  errors;
  bit  stim_done;
  bit  rx_idle_on;
  bit  hold_req;
  int  quiet_cycles;

  function automatic logic [63:0] pages_up(logic [63:0] a);
    return (a >> art_pkg::PageShift) + ((a & PgMask) != 0 ? 64'd1 : 64'd0);
  endfunction

  function automatic int region_at(logic [63:0] addr);
    logic [63:0] p;
    p = addr >> art_pkg::PageShift;
    for (int i = 0; i < mdl_used; i++) begin
      if (p < mdl_start[i]) return -1;
      if (p < mdl_end[i]) return i;
    end
    return -1;
  endfunction

  // Work out the result of one operation and update the shadow table
  function automatic art_pkg::out_item_t table_apply(art_pkg::in_item_t it);
    art_pkg::out_item_t r;
    logic [63:0] sp, ep, lp, lo, hi;
    int k, pos;
    r = '0;
    case (it.op)
      art_pkg::OpInsert: begin
        sp = it.addr_a >> art_pkg::PageShift;
        ep = pages_up(it.addr_b);
        r.status = art_pkg::StOk;
        if (it.addr_a >= it.addr_b || ep >= (64'd1 << art_pkg::PageW))
          r.status = art_pkg::StInvalid;
        else begin
          for (int i = 0; i < mdl_used; i++)
            if (sp < mdl_end[i] && mdl_start[i] < ep) r.status = art_pkg::StOverlap;
          if (r.status == art_pkg::StOk && mdl_used >= art_pkg::MaxRegions)
            r.status = art_pkg::StFull;
          if (r.status == art_pkg::StOk) begin
            pos = 0;
            while (pos < mdl_used && mdl_start[pos] < sp) pos++;
            for (int i = mdl_used; i > pos; i--) begin
              mdl_start[i] = mdl_start[i-1];
              mdl_end[i]   = mdl_end[i-1];
              mdl_flags[i] = mdl_flags[i-1];
            end
            mdl_start[pos] = sp[art_pkg::PageW-1:0];
            mdl_end[pos]   = ep[art_pkg::PageW-1:0];
            mdl_flags[pos] = it.region_flag_bits;
            mdl_used++;
          end
        end
      end
      art_pkg::OpRemove, art_pkg::OpFind: begin
        k = region_at(it.addr_a);
        if (k < 0) r.status = art_pkg::StMissing;
        else begin
          r.status    = art_pkg::StOk;
          r.hit_start = {mdl_start[k], 12'h000};
          r.hit_end   = {mdl_end[k], 12'h000};
          r.hit_flags = mdl_flags[k];
          if (it.op == art_pkg::OpRemove) begin
            for (int i = k; i + 1 < mdl_used; i++) begin
              mdl_start[i] = mdl_start[i+1];
              mdl_end[i]   = mdl_end[i+1];
              mdl_flags[i] = mdl_flags[i+1];
            end
            mdl_used--;
          end
        end
      end
      default: begin
        r.status = art_pkg::StInvalid;
        if (!(it.addr_a >= it.addr_b || it.req_length == 0 ||
              it.addr_b - it.addr_a < it.req_length)) begin
          sp = it.addr_a >> art_pkg::PageShift;
          ep = pages_up(it.addr_b);
          lp = pages_up(it.req_length);
          for (int i = 0; i <= mdl_used; i++) begin
            lo = (sp > 64'd4) ? sp : 64'd4;
            if (i > 0 && 64'(mdl_end[i-1]) > lo) lo = 64'(mdl_end[i-1]);
            hi = ep;
            if (i < mdl_used && 64'(mdl_start[i]) < hi) hi = 64'(mdl_start[i]);
            if (r.status != art_pkg::StOk && lo < hi && lp <= hi - lo) begin
              r.status = art_pkg::StOk;
              r.gap_address = lo << art_pkg::PageShift;
            end
          end
        end
      end
    endcase
    r.entries_used = 5'(mdl_used);
    return r;
  endfunction

  // Send one item, holding valid until the transfer
  task automatic send_item(art_pkg::in_item_t it);
    while ($urandom_range(99) < 7 && !rx_idle_on) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    result_queue.push_back(table_apply(it));
  endtask

  function automatic art_pkg::in_item_t mk(logic [1:0] op, logic [63:0] a,
                                           logic [63:0] b, logic [63:0] len,
                                           logic [7:0] fl);
    art_pkg::in_item_t it;
    it.op = op; it.addr_a = a; it.addr_b = b; it.req_length = len;
    it.region_flag_bits = fl;
    return it;
  endfunction

  // Random address mostly near the populated low window, sometimes near the top or anywhere
  function automatic logic [63:0] rand_addr();
    case ($urandom_range(9))
      0: return {$urandom, $urandom};
      1: return 64'hFFFF_FFFF_FFFF_F000 - 64'($urandom_range(65535));
      default: return 64'($urandom_range(32'h0008_0000));
    endcase
  endfunction

  // Directed table: expected typed in where obvious, else predictor
  typedef struct {
    art_pkg::in_item_t  item;
    bit                 typed;
    art_pkg::out_item_t want;
  } dir_row_t;

  function automatic art_pkg::out_item_t rs(logic [2:0] st, logic [63:0] hs,
                                            logic [63:0] he, logic [7:0] hf,
                                            logic [63:0] g, logic [4:0] n);
    art_pkg::out_item_t r;
    r.status = st; r.hit_start = hs; r.hit_end = he; r.hit_flags = hf;
    r.gap_address = g; r.entries_used = n;
    return r;
  endfunction

  initial begin
    dir_row_t rows[$];
    art_pkg::in_item_t it;
    art_pkg::out_item_t pred;
    int base;
    rst = 1'b1; in_valid = 1'b0; in_data = '0;
    errors = 0; stim_done = 0; hold_req = 0; rx_idle_on = 0;
    mdl_used = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    rows.push_back('{mk(art_pkg::OpFind, 64'h5000, 0, 0, 0), 1,
                     rs(art_pkg::StMissing, 0, 0, 0, 0, 0)});
    rows.push_back('{mk(art_pkg::OpRemove, '1, 0, 0, 0), 1,
                     rs(art_pkg::StMissing, 0, 0, 0, 0, 0)});
    rows.push_back('{mk(art_pkg::OpGap, 0, 64'h10000, 64'h1, 0), 1,
                     rs(art_pkg::StOk, 0, 0, 0, 64'h4000, 0)});
    rows.push_back('{mk(art_pkg::OpInsert, 64'h5000, 64'h5000, 0, 0), 1,
                     rs(art_pkg::StInvalid, 0, 0, 0, 0, 0)});
    rows.push_back('{mk(art_pkg::OpInsert, 0, '1, 0, 0), 1,
                     rs(art_pkg::StInvalid, 0, 0, 0, 0, 0)});
    rows.push_back('{mk(art_pkg::OpInsert, 64'h5123, 64'h6001, 0, 8'hFF), 1,
                     rs(art_pkg::StOk, 0, 0, 0, 0, 1)});
    rows.push_back('{mk(art_pkg::OpFind, 64'h6FFF, 0, 0, 0), 1,
                     rs(art_pkg::StOk, 64'h5000, 64'h7000, 8'hFF, 0, 1)});
    rows.push_back('{mk(art_pkg::OpInsert, 64'h6000, 64'h8000, 0, 0), 1,
                     rs(art_pkg::StOverlap, 0, 0, 0, 0, 1)});
    rows.push_back('{mk(art_pkg::OpInsert, 0, 64'h1000, 0, 8'h00), 0, '0});
    rows.push_back('{mk(art_pkg::OpInsert, 64'hFFFF_FFFF_FFFF_E000,
                        64'hFFFF_FFFF_FFFF_F000, 0, 8'hA5), 0, '0});
    rows.push_back('{mk(art_pkg::OpGap, 0, '1, 64'h1000, 0), 0, '0});
    rows.push_back('{mk(art_pkg::OpGap, 0, '1, '1, 0), 1,
                     rs(art_pkg::StInvalid, 0, 0, 0, 0, 3)});
    rows.push_back('{mk(art_pkg::OpGap, 0, '1, 0, 0), 1,
                     rs(art_pkg::StInvalid, 0, 0, 0, 0, 3)});
    rows.push_back('{mk(art_pkg::OpGap, 64'h9000, 64'h8000, 64'h1, 0), 1,
                     rs(art_pkg::StInvalid, 0, 0, 0, 0, 3)});
    rows.push_back('{mk(art_pkg::OpGap, 64'h4000, 64'h5800, 64'h1800, 0), 0, '0});
    rows.push_back('{mk(art_pkg::OpGap, 64'h7000, 64'hFFFF_FFFF_FFFF_FFFF,
                        64'h2000, 0), 0, '0});
    rows.push_back('{mk(art_pkg::OpRemove, 64'h5800, 0, 0, 0), 1,
                     rs(art_pkg::StOk, 64'h5000, 64'h7000, 8'hFF, 0, 2)});
    // Fill to capacity; the last of these and one more find the table full
    for (int i = 0; i < 15; i++)
      rows.push_back('{mk(art_pkg::OpInsert, 64'(32'h10000 + i * 32'h2000),
                          64'(32'h11000 + i * 32'h2000), 0, 8'(i)), 0, '0});
    rows.push_back('{mk(art_pkg::OpInsert, 64'h1000, 64'h2000, 0, 0), 1,
                     rs(art_pkg::StFull, 0, 0, 0, 0, 16)});
    rows.push_back('{mk(art_pkg::OpGap, 0, 64'h40000, 64'h1000, 0), 0, '0});
    rows.push_back('{mk(art_pkg::OpRemove, 0, 0, 0, 0), 0, '0});

    foreach (rows[i]) begin
      send_item(rows[i].item);
      if (rows[i].typed) begin
        pred = result_queue[$];
        if (pred !== rows[i].want) begin
          $display("%0t: table row %0d predictor disagrees: expected %h got %h",
                   $time, i, rows[i].want, pred);
          errors++;
        end
        result_queue[$] = rows[i].want;
      end
    end

    // Random part: mostly structured traffic with bursts of pressure
    for (int n = 0; n < NumRandom; n++) begin
      if (n == 300) hold_req = 1;
      if (n == 310) hold_req = 0;
      rx_idle_on = (n >= 600 && n < 750);
      it.op = 2'($urandom_range(3));
      if (mdl_used > 12 && $urandom_range(1)) it.op = art_pkg::OpRemove;
      base = $urandom_range(32'h80);
      it.addr_a = ($urandom_range(3) == 0) ? rand_addr()
                  : 64'(base) << art_pkg::PageShift |
                    64'($urandom_range(4095) * $urandom_range(1));
      it.addr_b = ($urandom_range(7) == 0) ? rand_addr()
                  : it.addr_a + 64'($urandom_range(32'h6000));
      it.req_length = ($urandom_range(7) == 0) ? {$urandom, $urandom}
                      : 64'($urandom_range(32'h8000));
      it.region_flag_bits = 8'($urandom);
      send_item(it);
    end
    in_valid <= 1'b0;
    stim_done = 1;
  end

  // Receiver: random stalls plus one long hold-off
  initial begin
    bit hold_done;
    hold_done = 0;
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      out_ready <= rx_idle_on ? 1'b1 : ($urandom_range(99) >= 7);
      @(posedge clk);
    end
  end

  // Result check
  always @(posedge clk) begin
    art_pkg::out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (result_queue.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        errors++;
      end else begin
        want = result_queue.pop_front();
        if (out_data.status !== want.status)
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   out_data.status);
        if (out_data.hit_start !== want.hit_start)
          $display("%0t: hit_start expected %h actual %h", $time, want.hit_start,
                   out_data.hit_start);
        if (out_data.hit_end !== want.hit_end)
          $display("%0t: hit_end expected %h actual %h", $time, want.hit_end,
                   out_data.hit_end);
        if (out_data.hit_flags !== want.hit_flags)
          $display("%0t: hit_flags expected %h actual %h", $time, want.hit_flags,
                   out_data.hit_flags);
        if (out_data.gap_address !== want.gap_address)
          $display("%0t: gap_address expected %h actual %h", $time, want.gap_address,
                   out_data.gap_address);
        if (out_data.entries_used !== want.entries_used)
          $display("%0t: entries_used expected %0d actual %0d", $time,
                   want.entries_used, out_data.entries_used);
        if (out_data !== want) errors++;
      end
    end
  end

  // Watchdog and end of run
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (stim_done && result_queue.size() == 0) begin
        repeat (100) @(posedge clk);
        if (errors == 0 && !out_valid) $display("** address_region_table: PASSED **");
        else $display("** address_region_table: FAILED **");
        $finish;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t: watchdog expired", $time);
        $display("** address_region_table: FAILED **");
        $finish;
      end
    end
  end
endmodule
